// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the core RTL.
// Define NO_ASSERTIONS to compile every macro to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- rtl/core/lfse_pkg.sv -----
// Package for the lagged-Fibonacci shuffle engine: request codes, constants
// and payload word types. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package lfse_pkg;
  localparam int unsigned TableLen = 55;
  localparam int unsigned TrailStart = 31;
  localparam logic [31:0] LcgMul = 32'd1664525;
  localparam logic [31:0] LcgAdd = 32'd1013904223;

  typedef enum logic [2:0] {
    REQ_SEED = 3'd0,
    REQ_DRAW = 3'd1,
    REQ_LOAD = 3'd2,
    REQ_CLEAR = 3'd3,
    REQ_SHUFFLE = 3'd4
  } req_t;

  typedef struct packed {
    logic [2:0] req_type;
    logic [31:0] seed_value;
    logic [31:0] modulo;
    logic [15:0] element;
    logic [15:0] previous_last;
    logic has_previous;
  } in_word_t;

  typedef struct packed {
    logic [31:0] value;
    logic last;
  } out_word_t;

  typedef struct packed {
    logic start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;
endpackage
`default_nettype wire

// ----- rtl/core/lagged_fibonacci_shuffle_engine_core.sv -----
// Lagged-Fibonacci (55/24) generator with Fisher-Yates shuffle engine.
// Draw: table reads, write back of the new lag word, then the iterative remainder.
// Seed: 55 LCG steps, each a multiply state and a write state; a zero-modulo draw answers next cycle.
// Shuffle of n words: a draw and swap per position, an optional anti-repeat check, then each word is emitted.
// Reset is synchronous; the table is cleared by a sweep of all 55 entries after reset.
// One request is worked at a time; results wait in an output register.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module lagged_fibonacci_shuffle_engine_core
  import lfse_pkg::*;
#(
  parameter int BUFFER_DEPTH = 64,
  parameter int ELEMENT_BITS = 16
) (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  output logic in_ready,
  input wire in_word_t in_data,
  output logic out_valid,
  input wire logic out_ready,
  output out_word_t out_data
);
  localparam int AW = $clog2(BUFFER_DEPTH);
  localparam int CW = $clog2(BUFFER_DEPTH + 1);

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_SEED_MUL, S_SEED_WR, S_DRAW_RD, S_DRAW_WAIT, S_DRAW_SUB,
    S_MOD_WAIT, S_DRAW_OUT, S_SH_RD_I, S_SH_RD_P, S_SH_WAIT, S_SH_WR_P,
    S_AR_RD, S_AR_WAIT, S_AR_WR, S_EM_RD, S_EM_WAIT, S_EM_OUT
  } state_t;

  logic [31:0] lag_mem [TableLen];
  logic [ELEMENT_BITS-1:0] buf_mem [BUFFER_DEPTH];

  state_t state_r;
  logic [5:0] lead_r, trail_r, idx_r;
  logic [31:0] lcg_r, mul_r;
  logic [31:0] lcg_nxt;
  logic [CW-1:0] cnt_r, i_r;
  logic [AW-1:0] p_r;
  logic [ELEMENT_BITS-1:0] ea_r, eb_r, prev_r;
  logic has_prev_r, shuffling_r;
  logic [31:0] bound_r;
  out_word_t out_r;
  logic out_v_r;

  logic tab_we;
  logic [5:0] tab_wa, tab_ra0, tab_ra1;
  logic [31:0] tab_wd;
  logic buf_we;
  logic [AW-1:0] buf_wa, buf_ra0, buf_ra1;
  logic [ELEMENT_BITS-1:0] buf_wd, buf_rd0_r, buf_rd1_r;
  logic [31:0] tab_rd0_r, tab_rd1_r;

  div_req_t div_req;
  logic div_busy;
  logic [31:0] div_rem;

  lfse_mod_unit u_mod (.clk(clk), .rst_n(rst_n), .req(div_req), .busy(div_busy),
    .rem(div_rem));

  // Memories: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (tab_we) lag_mem[tab_wa] <= tab_wd;
    tab_rd0_r <= lag_mem[tab_ra0];
    tab_rd1_r <= lag_mem[tab_ra1];
  end
  always_ff @(posedge clk) begin
    if (buf_we) buf_mem[buf_wa] <= buf_wd;
    buf_rd0_r <= buf_mem[buf_ra0];
    buf_rd1_r <= buf_mem[buf_ra1];
  end

  logic [5:0] lead_inc, trail_inc;
  assign lead_inc = (lead_r == 6'(TableLen - 1)) ? 6'd0 : lead_r + 6'd1;
  assign trail_inc = (trail_r == 6'(TableLen - 1)) ? 6'd0 : trail_r + 6'd1;
  assign lcg_nxt = mul_r + LcgAdd;

  assign in_ready = (state_r == S_IDLE) && !out_v_r;
  logic acc;
  assign acc = in_valid && in_ready;
  logic [CW-1:0] last_idx;
  assign last_idx = cnt_r - CW'(1);

  always_comb begin
    tab_we = 1'b0; tab_wa = idx_r; tab_wd = '0;
    tab_ra0 = lead_r; tab_ra1 = trail_r;
    buf_we = 1'b0; buf_wa = cnt_r[AW-1:0]; buf_wd = ELEMENT_BITS'(in_data.element);
    buf_ra0 = i_r[AW-1:0]; buf_ra1 = p_r;
    div_req = '0;
    case (state_r)
      S_CLR: begin
        tab_we = 1'b1;
      end
      S_IDLE: begin
        buf_we = acc && in_data.req_type == REQ_LOAD && cnt_r < CW'(BUFFER_DEPTH);
      end
      S_SEED_WR: begin
        tab_we = 1'b1; tab_wd = {1'b0, lcg_nxt[31:1]};
      end
      S_DRAW_SUB: begin
        tab_we = 1'b1; tab_wa = lead_r; tab_wd = tab_rd0_r - tab_rd1_r;
        div_req.start = 1'b1; div_req.dividend = tab_wd; div_req.divisor = bound_r;
      end
      S_SH_WAIT: begin
        buf_we = 1'b1; buf_wa = i_r[AW-1:0]; buf_wd = buf_rd1_r;
      end
      S_SH_WR_P: begin
        buf_we = 1'b1; buf_wa = p_r; buf_wd = ea_r;
      end
      S_AR_RD: begin
        buf_ra0 = '0; buf_ra1 = last_idx[AW-1:0];
      end
      S_AR_WAIT: begin
        if (buf_rd0_r == prev_r) begin
          buf_we = 1'b1; buf_wa = last_idx[AW-1:0]; buf_wd = buf_rd0_r;
        end
      end
      S_AR_WR: begin
        if (ea_r == prev_r) begin
          buf_we = 1'b1; buf_wa = '0; buf_wd = eb_r;
        end
      end
      S_EM_RD: begin
        buf_ra0 = i_r[AW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      idx_r <= '0;
      lead_r <= '0;
      trail_r <= 6'(TrailStart);
      cnt_r <= '0;
      out_v_r <= 1'b0;
      shuffling_r <= 1'b0;
    end else begin
      if (out_v_r && out_ready) out_v_r <= 1'b0;
      case (state_r)
        S_CLR: begin
          idx_r <= idx_r + 6'd1;
          if (idx_r == 6'(TableLen - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (acc) begin
            prev_r <= ELEMENT_BITS'(in_data.previous_last);
            has_prev_r <= in_data.has_previous;
            case (in_data.req_type)
              REQ_SEED: begin
                lcg_r <= in_data.seed_value; idx_r <= '0; state_r <= S_SEED_MUL;
              end
              REQ_DRAW: begin
                shuffling_r <= 1'b0;
                bound_r <= in_data.modulo;
                if (in_data.modulo == 32'd0) begin
                  out_r <= '{value: 32'd0, last: 1'b1}; out_v_r <= 1'b1;
                end else begin
                  lead_r <= lead_inc; trail_r <= trail_inc; state_r <= S_DRAW_RD;
                end
              end
              REQ_LOAD: if (cnt_r < CW'(BUFFER_DEPTH)) cnt_r <= cnt_r + CW'(1);
              REQ_CLEAR: cnt_r <= '0;
              REQ_SHUFFLE: begin
                if (cnt_r == CW'(1)) begin
                  i_r <= '0; state_r <= S_EM_RD;
                end else if (cnt_r != '0) begin
                  i_r <= CW'(1);
                  shuffling_r <= 1'b1; bound_r <= 32'd2;
                  lead_r <= lead_inc; trail_r <= trail_inc; state_r <= S_DRAW_RD;
                end
              end
              default: ;
            endcase
          end
        end
        S_SEED_MUL: begin
          mul_r <= lcg_r * LcgMul; state_r <= S_SEED_WR;
        end
        S_SEED_WR: begin
          lcg_r <= lcg_nxt;
          idx_r <= idx_r + 6'd1;
          if (idx_r == 6'(TableLen - 1)) begin
            lead_r <= '0; trail_r <= 6'(TrailStart); state_r <= S_IDLE;
          end else begin
            state_r <= S_SEED_MUL;
          end
        end
        S_DRAW_RD: state_r <= S_DRAW_WAIT;
        S_DRAW_WAIT: state_r <= S_DRAW_SUB;
        S_DRAW_SUB: state_r <= S_MOD_WAIT;
        S_MOD_WAIT: begin
          if (!div_busy) begin
            if (shuffling_r) begin
              p_r <= div_rem[AW-1:0]; state_r <= S_SH_RD_P;
            end else begin
              state_r <= S_DRAW_OUT;
            end
          end
        end
        S_DRAW_OUT: begin
          out_r <= '{value: div_rem, last: 1'b1}; out_v_r <= 1'b1; state_r <= S_IDLE;
        end
        S_SH_RD_P: state_r <= S_SH_WAIT;
        S_SH_WAIT: begin
          ea_r <= buf_rd0_r; state_r <= S_SH_WR_P;
        end
        S_SH_WR_P: begin
          if (i_r == last_idx) begin
            shuffling_r <= 1'b0;
            state_r <= (has_prev_r) ? S_AR_RD : S_EM_RD;
            i_r <= '0;
          end else begin
            i_r <= i_r + CW'(1);
            bound_r <= 32'(i_r) + 32'd2;
            lead_r <= lead_inc; trail_r <= trail_inc; state_r <= S_DRAW_RD;
          end
        end
        S_AR_RD: state_r <= S_AR_WAIT;
        S_AR_WAIT: begin
          ea_r <= buf_rd0_r; eb_r <= buf_rd1_r; state_r <= S_AR_WR;
        end
        S_AR_WR: begin
          state_r <= S_EM_RD;
        end
        S_EM_RD: if (!out_v_r || out_ready) state_r <= S_EM_WAIT;
        S_EM_WAIT: state_r <= S_EM_OUT;
        S_EM_OUT: begin
          out_r <= '{value: 32'(buf_rd0_r), last: (i_r == last_idx)};
          out_v_r <= 1'b1;
          if (i_r == last_idx) state_r <= S_IDLE;
          else begin
            i_r <= i_r + CW'(1); state_r <= S_EM_RD;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_v_r;
  assign out_data = out_r;

  `ASSERT_IMPL(a_no_accept_busy, clk, rst_n, in_valid && in_ready,
      state_r == S_IDLE && !out_v_r, "accepted while busy")
  `ASSERT_IMPL(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= CW'(BUFFER_DEPTH),
      "buffer count overflow")
  `ASSERT_IMPL(a_lead_range, clk, rst_n, 1'b1,
      lead_r < 6'(TableLen) && trail_r < 6'(TableLen), "cursor out of range")
  `ASSERT_IMPL(a_p_le_i, clk, rst_n, state_r == S_SH_RD_P, 32'(p_r) <= 32'(i_r),
      "shuffle index above position")
endmodule
`default_nettype wire

// ----- rtl/core/lfse_mod_unit.sv -----
// Iterative 32-bit unsigned remainder unit, one quotient bit per cycle.
// Depends on lfse_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module lfse_mod_unit
  import lfse_pkg::*;
(
  input wire logic clk,
  input wire logic rst_n,
  input wire div_req_t req,
  output logic busy,
  output logic [31:0] rem
);
  logic [32:0] rem_r;
  logic [31:0] quo_r, div_r;
  logic [5:0] cnt_r;
  logic [32:0] shifted, diff;

  always_comb begin
    shifted = {rem_r[31:0], quo_r[31]};
    diff = shifted - {1'b0, div_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (req.start) begin
      rem_r <= '0;
      quo_r <= req.dividend;
      div_r <= req.divisor;
      cnt_r <= 6'd32;
    end else if (cnt_r != 6'd0) begin
      rem_r <= diff[32] ? shifted : diff;
      quo_r <= {quo_r[30:0], 1'b0};
      cnt_r <= cnt_r - 6'd1;
    end
  end

  assign busy = (cnt_r != 6'd0);
  assign rem = rem_r[31:0];

  `ASSERT_IMPL(a_cnt_range, clk, rst_n, 1'b1, cnt_r <= 6'd32, "mod count out of range")
  `ASSERT_NEXT(a_start_load, clk, rst_n, req.start, cnt_r == 6'd32, "mod start lost")
  `ASSERT_IMPL(a_rem_below, clk, rst_n, busy && div_r != 32'd0, rem_r < {1'b0, div_r},
      "partial remainder too large")
endmodule
`default_nettype wire

// ----- bench/lfse_checker.sv -----
// Checker for the lagged-Fibonacci shuffle engine: watches both channels,
// predicts each result word and compares. Depends on lfse_pkg.
`timescale 1ns / 1ps
module lfse_checker
  import lfse_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input in_word_t in_data,
  input logic out_valid,
  input logic out_ready,
  input out_word_t out_data,
  output int errors,
  output int pending,
  output int draws_seen,
  output int shuffles_seen
);
  logic [31:0] lag [55];
  int unsigned lead_pos;
  int unsigned trail_pos;
  logic [15:0] perm [64];
  int unsigned perm_len;
  out_word_t want_q[$];

  assign pending = want_q.size();

  function automatic logic [31:0] step_draw(logic [31:0] bound);
    logic [31:0] w;
    if (bound == 0) return 0;
    lead_pos = (lead_pos + 1) % 55;
    trail_pos = (trail_pos + 1) % 55;
    w = lag[lead_pos] - lag[trail_pos];
    lag[lead_pos] = w;
    return w % bound;
  endfunction

  task automatic predict(in_word_t w);
    logic [31:0] v;
    logic [31:0] p;
    logic [15:0] t;
    out_word_t r;
    case (w.req_type)
      REQ_SEED: begin
        v = w.seed_value;
        for (int i = 0; i < 55; i++) begin
          v = v * LcgMul + LcgAdd;
          lag[i] = v >> 1;
        end
        lead_pos = 0;
        trail_pos = TrailStart;
      end
      REQ_DRAW: begin
        r.value = step_draw(w.modulo);
        r.last = 1'b1;
        want_q.push_back(r);
        draws_seen++;
      end
      REQ_LOAD: begin
        if (perm_len < 64) begin
          perm[perm_len] = w.element;
          perm_len++;
        end
      end
      REQ_CLEAR: perm_len = 0;
      REQ_SHUFFLE: begin
        if (perm_len != 0) begin
          for (int i = 1; i < perm_len; i++) begin
            p = step_draw(i + 1);
            t = perm[i];
            perm[i] = perm[p];
            perm[p] = t;
          end
          if (w.has_previous && perm_len > 1 && perm[0] == w.previous_last) begin
            t = perm[0];
            perm[0] = perm[perm_len - 1];
            perm[perm_len - 1] = t;
          end
          for (int i = 0; i < perm_len; i++) begin
            r.value = {16'd0, perm[i]};
            r.last = (i + 1 == perm_len);
            want_q.push_back(r);
          end
          shuffles_seen++;
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    out_word_t e;
    if (!rst_n) begin
      for (int i = 0; i < 55; i++) lag[i] = 0;
      lead_pos = 0;
      trail_pos = TrailStart;
      perm_len = 0;
      want_q.delete();
      errors = 0;
      draws_seen = 0;
      shuffles_seen = 0;
    end else begin
      if (in_valid && in_ready) predict(in_data);
      if (out_valid && out_ready) begin
        if (want_q.size() == 0) begin
          $error("unexpected result word value=%h last=%b", out_data.value, out_data.last);
          errors++;
        end else begin
          e = want_q.pop_front();
          if (out_data.value !== e.value) begin
            $error("value: expected %h, actual %h", e.value, out_data.value);
            errors++;
          end
          if (out_data.last !== e.last) begin
            $error("last: expected %b, actual %b", e.last, out_data.last);
            errors++;
          end
        end
      end
    end
  end
endmodule

// ----- bench/testbench.sv -----
// Testbench top for the lagged-Fibonacci shuffle engine: clock, reset,
// stimulus and verdict. Depends on lfse_pkg, the core and lfse_checker.
`timescale 1ns / 1ps
module testbench;
  import lfse_pkg::*;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_word_t in_data;
  logic out_valid;
  logic out_ready;
  out_word_t out_data;
  int errors;
  int pending;
  int draws_seen;
  int shuffles_seen;
  int fill_level;
  int sent;
  logic [15:0] last_emitted;

  lagged_fibonacci_shuffle_engine_core u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  lfse_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .errors(errors), .pending(pending),
    .draws_seen(draws_seen), .shuffles_seen(shuffles_seen)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #500ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      last_emitted <= 0;
    end else if (out_valid && out_ready && out_data.last) begin
      last_emitted <= out_data.value[15:0];
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(20, 150);
  endfunction

  initial begin
    out_ready = 0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
      if ($urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat (gap_len()) @(posedge clk);
      end
    end
  end

  task automatic send(in_word_t w);
    int g;
    g = gap_len();
    if ($urandom_range(0, 2) != 0) g = 0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
    if (w.req_type == REQ_LOAD && fill_level < 64) fill_level++;
    if (w.req_type == REQ_CLEAR) fill_level = 0;
  endtask

  function automatic in_word_t make_req(logic [2:0] kind);
    in_word_t w;
    w.req_type = kind;
    w.seed_value = $urandom;
    w.modulo = $urandom;
    w.element = 16'($urandom);
    w.previous_last = 16'($urandom);
    w.has_previous = 1'($urandom_range(0, 1));
    return w;
  endfunction

  task automatic send_draw(logic [31:0] bound);
    in_word_t w;
    w = make_req(REQ_DRAW);
    w.modulo = bound;
    send(w);
  endtask

  task automatic send_load(logic [15:0] value);
    in_word_t w;
    w = make_req(REQ_LOAD);
    w.element = value;
    send(w);
  endtask

  task automatic send_shuffle(logic [15:0] prev, logic use_prev);
    in_word_t w;
    w = make_req(REQ_SHUFFLE);
    w.previous_last = prev;
    w.has_previous = use_prev;
    send(w);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    in_word_t w;
    int pick;
    bit mid_drained;
    in_valid = 0;
    in_data = '0;
    rst_n = 0;
    fill_level = 0;
    sent = 0;
    mid_drained = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_draw(32'd7);
    send_draw(32'd0);
    w = make_req(REQ_SEED);
    w.seed_value = 32'd0;
    send(w);
    send_draw(32'hFFFF_FFFF);
    send_draw(32'd1);
    send_draw(32'd0);
    send_shuffle(16'd0, 1'b1);
    send_load(16'hFFFF);
    send_shuffle(16'hFFFF, 1'b1);
    send_load(16'h0000);
    send_load(16'h1234);
    send_shuffle(16'h0000, 1'b1);
    send_shuffle(16'hFFFF, 1'b0);
    w = make_req(REQ_SEED);
    w.seed_value = 32'hFFFF_FFFF;
    send(w);
    w = make_req(3'd5);
    send(w);
    w = make_req(3'd7);
    send(w);
    send(make_req(REQ_CLEAR));
    for (int i = 0; i < 66; i++) send_load(i[15:0]);
    send_shuffle(last_emitted, 1'b1);
    drain();

    while (sent < 410) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        send(make_req(REQ_SEED));
      end else if (pick < 40) begin
        case ($urandom_range(0, 4))
          0: send_draw(32'd0);
          1: send_draw($urandom_range(1, 100));
          2: send_draw(32'hFFFF_FFFF - $urandom_range(0, 3));
          default: send_draw($urandom);
        endcase
      end else if (pick < 85) begin
        if ($urandom_range(0, 9) == 0) send(make_req(REQ_CLEAR));
        send_load(16'($urandom));
      end else if (pick < 88) begin
        send(make_req(3'(5 + $urandom_range(0, 2))));
      end else begin
        if (fill_level > 12 && $urandom_range(0, 3) != 0) begin
          send(make_req(REQ_CLEAR));
          repeat ($urandom_range(1, 8)) send_load(16'($urandom_range(0, 3)));
        end
        send_shuffle($urandom_range(0, 1) ? last_emitted : 16'($urandom_range(0, 3)),
                     $urandom_range(0, 3) != 0);
      end
      if (!mid_drained && sent >= 250) begin
        drain();
        mid_drained = 1'b1;
      end
    end

    drain();
    repeat (300) @(posedge clk);
    $display("Covered %0d draws and %0d non-empty shuffles, with seeding, loads, clears",
             draws_seen, shuffles_seen);
    $display("and ignored request codes, under random stalls on both channels.");
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

// ----- lagged_fibonacci_shuffle_engine_core.f -----
+incdir+rtl/core
rtl/core/lfse_pkg.sv
rtl/core/lfse_mod_unit.sv
rtl/core/lagged_fibonacci_shuffle_engine_core.sv
bench/lfse_checker.sv
bench/testbench.sv
